// ===== rtl/sbms_pkg.sv =====
`timescale 1ns / 1ps
// Shared-buffer multi-stack: sizes, pointer widths and codes.
// No dependencies; imported by the core and its checker.
package sbms_pkg;

    localparam int CAPACITY   = 16;
    localparam int STACKS     = 4;
    localparam int DATA_WIDTH = 32;

    // pointer holds a slot number or the null value CAPACITY
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int STK_W  = (STACKS > 1) ? $clog2(STACKS) : 1;

    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(CAPACITY);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

endpackage

// ===== rtl/sbms_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/shared_buffer_multi_stack_core.sv =====
`timescale 1ns / 1ps
// Top level: several LIFO stacks sharing one slot store through a linked free list.
// Depends on sbms_pkg and sbms_ram.
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+-----------------------------------
//  command   | cmd, stack_id, push_data       | taken when start && !busy
//  result    | pop_data, status               | done high for one cycle, no stall
//
// Each item: the accept edge issues reads of the link and data
// RAMs, the next edge applies the update and registers the result (done).
// The link read of the free head or stack top bounds the rate.
// A new start is taken in the cycle done is high.
// After reset every stack is empty and all slots are free; no clearing pass:
// the untouched tail of the initial free chain is tracked by a fill count.
// The result side cannot stall; done is a one-cycle strobe.
module shared_buffer_multi_stack_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cmd,
    input  logic [1:0]          stack_id,
    input  logic signed [31:0]  push_data,
    output logic                done,
    output logic signed [31:0]  pop_data,
    output logic [1:0]          status
);

    import sbms_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                 state_reg;
    logic                   cmd_reg;
    logic [1:0]             sid_reg;
    logic [31:0]            data_reg;
    logic                   done_reg;
    logic [31:0]            pop_data_reg;
    logic [1:0]             status_reg;

    // stack tops, free head and count of slots ever handed out
    logic [PTR_W-1:0]       top_reg [STACKS];
    logic [PTR_W-1:0]       free_head_reg;
    logic [PTR_W-1:0]       fill_reg;

    logic                   accept;
    logic [STK_W-1:0]       in_idx;
    logic [STK_W-1:0]       cur_idx;
    logic [PTR_W-1:0]       in_top;
    logic [PTR_W-1:0]       cur_top;
    logic                   sid_ok;

    logic [SLOT_W-1:0]      link_raddr;
    logic [SLOT_W-1:0]      data_raddr;
    logic [PTR_W-1:0]       link_rdata;
    logic [DATA_WIDTH-1:0]  data_rdata;

    logic                   link_we;
    logic [SLOT_W-1:0]      link_waddr;
    logic [PTR_W-1:0]       link_wdata;
    logic                   data_we;

    logic                   push_ok;
    logic                   pop_ok;
    logic [PTR_W-1:0]       next_free;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);

    assign in_idx  = STK_W'(stack_id);
    assign cur_idx = STK_W'(sid_reg);
    assign in_top  = top_reg[in_idx];
    assign cur_top = top_reg[cur_idx];
    assign sid_ok  = ({30'd0, sid_reg} < 32'(STACKS));

    // read side: push walks the free list, pop walks the stack
    assign link_raddr = (cmd_t'(cmd) == CMD_PUSH) ? SLOT_W'(free_head_reg) : SLOT_W'(in_top);
    assign data_raddr = SLOT_W'(in_top);

    assign push_ok = (state_reg == S_EXEC) && (cmd_t'(cmd_reg) == CMD_PUSH)
                     && sid_ok && (free_head_reg != PTR_NULL);
    assign pop_ok  = (state_reg == S_EXEC) && (cmd_t'(cmd_reg) == CMD_POP)
                     && sid_ok && (cur_top != PTR_NULL);

    // A free head equal to the fill count is in the never-written tail,
    // whose link is implicitly the next slot number.
    always_comb
    begin
        if (free_head_reg == fill_reg)
        begin
            next_free = (free_head_reg == PTR_LAST) ? PTR_NULL : free_head_reg + PTR_W'(1);
        end
        else
        begin
            next_free = link_rdata;
        end
    end

    always_comb
    begin
        link_we    = push_ok || pop_ok;
        data_we    = push_ok;
        link_waddr = push_ok ? SLOT_W'(free_head_reg) : SLOT_W'(cur_top);
        link_wdata = push_ok ? cur_top : free_head_reg;
    end

    sbms_ram #(
        .WIDTH (PTR_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    sbms_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (SLOT_W'(free_head_reg)),
        .wdata (DATA_WIDTH'(data_reg)),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    // captured command fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            sid_reg  <= stack_id;
            data_reg <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            pop_data_reg  <= '0;
            status_reg    <= ST_OK;
            free_head_reg <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < STACKS; i++)
            begin
                top_reg[i] <= PTR_NULL;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                    if (push_ok)
                    begin
                        top_reg[cur_idx] <= free_head_reg;
                        free_head_reg    <= next_free;
                        if (free_head_reg == fill_reg)
                        begin
                            fill_reg <= fill_reg + PTR_W'(1);
                        end
                        pop_data_reg <= '0;
                        status_reg   <= ST_OK;
                    end
                    else if (pop_ok)
                    begin
                        top_reg[cur_idx] <= link_rdata;
                        free_head_reg    <= cur_top;
                        pop_data_reg     <= 32'($signed(data_rdata));
                        status_reg       <= ST_OK;
                    end
                    else
                    begin
                        pop_data_reg <= '0;
                        status_reg   <= (cmd_t'(cmd_reg) == CMD_PUSH) ? ST_OVERFLOW
                                                                      : ST_UNDERFLOW;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign pop_data = pop_data_reg;
    assign status   = status_reg;

endmodule

// ===== rtl/sbms_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for shared_buffer_multi_stack_core, bound to the top level.
// Depends on sbms_pkg.
module sbms_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] pop_data,
    input logic [1:0]         status
);

    import sbms_pkg::*;

    // every accepted item is worked on in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the core busy");

    // work on an item always ends in a result in the next cycle, with the core idle again
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("busy cycle not followed by a result");

    // a result appears only after work on an item
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("result without an item in work");

    // errors carry zero data and a defined code
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (pop_data == 32'sd0)
            && (status == ST_OVERFLOW || status == ST_UNDERFLOW))
        else $error("error result with bad data or code");

endmodule

bind shared_buffer_multi_stack_core sbms_checker u_sbms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .pop_data (pop_data),
    .status   (status)
);
